/* sv/stq_pkg.sv */
// Package for the sorted timeout queue: payload types, codes and constants.
`default_nettype none
package stq_pkg;

  localparam logic [29:0] NSEC_TOP = 30'd999999999;
  localparam logic [29:0] ONE_SECOND_NS = 30'd1000000000;
  localparam logic [31:0] INT_MAX = 32'd2147483647;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_POLL = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_FIRED   = 3'd2,
    ST_PENDING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  queue_id;
    logic [15:0] handler_id;
    logic [15:0] context_id;
    logic [31:0] timeout_seconds;
    logic [29:0] timeout_nanoseconds;
    logic [31:0] elapsed_seconds;
    logic [29:0] elapsed_nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_handler;
    logic [15:0] fired_context;
    logic [7:0]  fired_queue;
    logic [30:0] wait_seconds;
    logic [29:0] wait_nanoseconds;
    logic [4:0]  removed_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] secs;
    logic [29:0] nsecs;
    logic [15:0] handler;
    logic [15:0] context_id;
    logic [7:0]  queue;
  } entry_t;

endpackage
`default_nettype wire

/* sv/sorted_timeout_queue_top.sv */
// Top level of the sorted timeout queue: entry store, scan sequencer, result register.
//
// Input channel in_data/in_valid/in_stall carries one command item (add, delete, poll).
// Output channel out_data/out_valid/out_stall returns exactly one result item per command.
// The block takes one command at a time. A command reads entries one per cycle from
// the entry memory and writes the compacted or shifted list back one per cycle through
// a single shared update unit (elapsed-time charge, match and order compare).
// The result is registered after the walk over the held entries and the decide step,
// and the next item is taken only after that result has been taken; the walk over the
// held entries sets how long this takes when the result is not stalled.
// An add to a full table first charges and drops a duplicate in one walk; when that
// frees a slot, a second walk inserts the new entry.
// The result waits in an output register until taken; in_stall stays high meanwhile.
// Reset (rst, synchronous) empties the table; entry contents are not cleared, only the
// fill count. A stalled result holds its value until out_stall drops.
`default_nettype none
module sorted_timeout_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire stq_pkg::in_item_t  in_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output stq_pkg::out_item_t      out_data,
  output logic                    out_valid,
  input  wire logic               out_stall
);
  import stq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];

  state_t state, state_next;
  in_item_t cmd;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic          dup_done;
  logic          inserted;
  logic          rescan_pass;
  logic [CW-1:0] removed;
  logic          rd_pend;
  logic [CW-1:0] rd_pend_idx;
  entry_t        rd_data;
  entry_t        held;
  logic          held_vld;
  entry_t        head;
  out_item_t     result;

  // Shared update unit: charge elapsed time and classify one entry.
  entry_t  chg;
  logic    drop;
  logic    later;
  logic [29:0] en_c, tn_c;
  entry_t  new_e;
  logic    ins_en;
  logic    put_new;
  logic    rescan;

  always_comb begin
    en_c = (cmd.elapsed_nanoseconds > NSEC_TOP) ? NSEC_TOP : cmd.elapsed_nanoseconds;
    tn_c = (cmd.timeout_nanoseconds > NSEC_TOP) ? NSEC_TOP : cmd.timeout_nanoseconds;
    new_e = '{secs: cmd.timeout_seconds, nsecs: tn_c, handler: cmd.handler_id,
              context_id: cmd.context_id, queue: cmd.queue_id};
    chg = rd_data;
    if ((cmd.command == CMD_ADD && !rescan_pass) || cmd.command == CMD_POLL) begin
      if (cmd.elapsed_seconds > rd_data.secs) begin
        chg.secs = '0;
        chg.nsecs = '0;
      end else begin
        chg.secs = rd_data.secs - cmd.elapsed_seconds;
        if (en_c > rd_data.nsecs) begin
          if (chg.secs == '0) begin
            chg.nsecs = '0;
          end else begin
            chg.secs = chg.secs - 32'd1;
            chg.nsecs = ONE_SECOND_NS - (en_c - rd_data.nsecs);
          end
        end else begin
          chg.nsecs = rd_data.nsecs - en_c;
        end
      end
    end
    drop = 1'b0;
    unique case (cmd.command)
      CMD_ADD: drop = !dup_done && chg.handler == cmd.handler_id &&
                      chg.context_id == cmd.context_id;
      CMD_DEL: drop = (cmd.queue_id == '0 || chg.queue == cmd.queue_id) &&
                      chg.context_id == cmd.context_id &&
                      (cmd.handler_id == '0 || chg.handler == cmd.handler_id);
      CMD_POLL: drop = (rd_pend_idx == '0) && chg.secs == '0 && chg.nsecs == '0;
      default: drop = 1'b0;
    endcase
    later = (cmd.timeout_seconds < chg.secs) ||
            (cmd.timeout_seconds == chg.secs && tn_c < chg.nsecs);
    // A full table only charges and drops the duplicate; insertion waits for a free slot.
    ins_en = (cmd.command == CMD_ADD) && (count < CW'(DEPTH));
    put_new = ins_en && !inserted && later;
    rescan = (state == S_DECIDE) && (cmd.command == CMD_ADD) && !ins_en &&
             (wr_idx < CW'(DEPTH));
  end

  // Write port: in ADD, a held entry is written while the new one may be inserted.
  logic           wr_en;
  logic [CW-1:0]  wr_addr;
  entry_t         wr_data;
  logic           scan_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        cmd <= in_data;
        rd_idx <= '0;
        wr_idx <= '0;
        rd_pend <= 1'b0;
        dup_done <= 1'b0;
        inserted <= 1'b0;
        rescan_pass <= 1'b0;
        removed <= '0;
        held_vld <= 1'b0;
      end
      if (state == S_SCAN) begin
        rd_pend <= (rd_idx < count);
        rd_pend_idx <= rd_idx;
        if (rd_idx < count) rd_idx <= rd_idx + 1'b1;
        if (rd_pend) begin
          if (rd_pend_idx == '0 && cmd.command == CMD_POLL) head <= chg;
          if (drop) begin
            removed <= removed + 1'b1;
            if (cmd.command == CMD_ADD) dup_done <= 1'b1;
          end else begin
            if (put_new) begin
              inserted <= 1'b1;
              held <= chg;
              held_vld <= 1'b1;
            end else if (held_vld) begin
              held <= chg;
            end
            wr_idx <= wr_idx + 1'b1;
          end
        end
      end
      if (state == S_DECIDE) begin
        if (ins_en) count <= wr_idx + 1'b1;
        else count <= wr_idx;
      end
      // Walk again to insert once the duplicate has freed a slot.
      if (rescan) begin
        rd_idx <= '0;
        wr_idx <= '0;
        rd_pend <= 1'b0;
        inserted <= 1'b0;
        held_vld <= 1'b0;
        rescan_pass <= 1'b1;
      end
      if (state == S_DECIDE && !rescan) begin
        out_valid <= 1'b1;
        out_data <= result;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Poll pops only an expired head; entries after it all shift down by one.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = wr_idx;
    wr_data = chg;
    scan_done = (state == S_SCAN) && !rd_pend && (rd_idx >= count);
    if (state == S_SCAN && rd_pend && !drop) begin
      if (put_new) begin
        wr_en = 1'b1;
        wr_data = new_e;
      end else if (held_vld) begin
        wr_en = 1'b1;
        wr_data = held;
      end else begin
        wr_en = 1'b1;
      end
    end
    if (state == S_DECIDE && ins_en) begin
      wr_en = 1'b1;
      wr_data = held_vld ? held : new_e;
    end
    if (cmd.command == CMD_POLL && rd_pend && drop) wr_en = 1'b0;
  end

  // Memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[IW-1:0]] <= wr_data;
    rd_data <= mem[rd_idx[IW-1:0]];
  end

  // Result formation.
  always_comb begin
    result = '0;
    result.status = ST_DONE;
    unique case (cmd.command)
      CMD_ADD: if (wr_idx >= CW'(DEPTH)) result.status = ST_FULL;
      CMD_DEL: result.removed_count = (32'(removed) > 32'd31) ? 5'd31 : 5'(removed);
      CMD_POLL: begin
        if (count == '0) begin
          result.status = ST_EMPTY;
        end else if (removed != '0) begin
          result.status = ST_FIRED;
          result.fired_handler = head.handler;
          result.fired_context = head.context_id;
          result.fired_queue = head.queue;
        end else begin
          result.status = ST_PENDING;
          if (head.secs > INT_MAX) begin
            result.wait_seconds = INT_MAX[30:0];
          end else begin
            result.wait_seconds = head.secs[30:0];
            result.wait_nanoseconds = head.nsecs;
          end
        end
      end
      default: result.status = ST_DONE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_DECIDE;
      S_DECIDE: state_next = rescan ? S_SCAN : S_OUT;
      S_OUT:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
  end

  // Table never overflows.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count above depth");
  // A result appears only after the decide step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("result without decide");
  // No new item is taken while a result is held.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("accept while result pending");

endmodule
`default_nettype wire
